FILE: hdl/edd_pkg.sv
// Package for the error diffusion ditherer.
// Holds configuration codes, fixed field widths and the pixel control word.
// No dependencies.
`default_nettype none

package edd_pkg;

  localparam int PIX_W        = 8;
  localparam int CFG_W        = 12;
  localparam int ROW_W        = 11;
  localparam int MAX_HEIGHT   = 2048;
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic first_row;
    logic has_left;
    logic last_col;
    logic frame_end;
  } pix_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/edd_line_buf.sv
// Line buffer holding next-row errors, one word per column.
// Clears itself after reset; registered read with same-edge write bypass.
// Depends on nothing but its parameters.
`default_nettype none

module edd_line_buf #(
  parameter int DEPTH  = 2048,
  parameter int WORD_W = 30
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WORD_W-1:0]        rd_data_o,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WORD_W-1:0]        wr_data_i,
  output logic                          busy_o
);

  localparam int AW = $clog2(DEPTH);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_q;
  logic [WORD_W-1:0] byp_q;
  logic              byp_hit_q;
  logic              busy_q;
  logic [AW-1:0]     clr_addr_q;
  logic              port_we;
  logic [AW-1:0]     port_addr;
  logic [WORD_W-1:0] port_data;

  always_comb begin
    if (busy_q) begin
      port_we   = 1'b1;
      port_addr = clr_addr_q;
      port_data = '0;
    end else begin
      port_we   = wr_en_i;
      port_addr = wr_addr_i;
      port_data = wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b1;
      clr_addr_q <= '0;
    end else if (busy_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (port_we) begin
      mem[port_addr] <= port_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
      byp_q   <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_hit_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_hit_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = byp_hit_q ? byp_q : rdata_q;
  assign busy_o    = busy_q;

  a_no_read_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !rd_en_i)
    else $error("line buffer read during clear pass");

  a_clear_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && (clr_addr_q == AW'(DEPTH - 1)) |=> !busy_q)
    else $error("clear pass did not finish at last entry");

  a_bypass_only_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rd_en_i |=> $stable(byp_hit_q))
    else $error("bypass flag changed without a read");

endmodule

`default_nettype wire

FILE: hdl/edd_chan.sv
// One colour channel: error add, saturate, threshold and error shares.
// Keeps the right carry and the two pending next-row sums of the channel.
// Depends on edd_pkg.
`default_nettype none

module edd_chan #(
  parameter int ERR_BITS = 10
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        adv_i,
  input  wire edd_pkg::pix_ctrl_t          ctrl_i,
  input  wire logic [edd_pkg::PIX_W-1:0]   pix_i,
  input  wire logic signed [ERR_BITS-1:0]  line_err_i,
  output logic                             bit_o,
  output logic signed [ERR_BITS-1:0]       below_left_o,
  output logic signed [ERR_BITS-1:0]       below_o
);

  localparam int VW = ERR_BITS + 3;
  localparam int PW = 12;

  function automatic logic signed [ERR_BITS-1:0] sat_err(input logic signed [ERR_BITS:0] s);
    logic signed [ERR_BITS-1:0] r;
    if (s[ERR_BITS] != s[ERR_BITS-1]) begin
      r = s[ERR_BITS] ? {1'b1, {(ERR_BITS-1){1'b0}}} : {1'b0, {(ERR_BITS-1){1'b1}}};
    end else begin
      r = s[ERR_BITS-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [7:0] share16(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = p + (p[PW-1] ? PW'(15) : PW'(0));
    return 8'(t >>> 4);
  endfunction

  logic signed [ERR_BITS-1:0] rc_q, pc_q, pn_q;
  logic signed [ERR_BITS-1:0] pc_new;
  logic signed [VW-1:0]       v;
  logic [7:0]                 val;
  logic                       on;
  logic signed [8:0]          e;
  logic signed [PW-1:0]       p1, p3, p5, p7;
  logic signed [7:0]          s1, s3, s5, s7;

  always_comb begin
    v = VW'($signed({1'b0, pix_i})) + VW'(rc_q)
        + (ctrl_i.first_row ? VW'(0) : VW'(line_err_i));
    if (v[VW-1]) begin
      val = 8'd0;
    end else if (v[VW-2:8] != '0) begin
      val = 8'd255;
    end else begin
      val = v[7:0];
    end
    on = val[7];
    e  = $signed({1'b0, val}) - (on ? 9'sd255 : 9'sd0);
    p1 = PW'(e);
    p3 = PW'(e) * 12'sd3;
    p5 = PW'(e) * 12'sd5;
    p7 = PW'(e) * 12'sd7;
    s1 = share16(p1);
    s3 = share16(p3);
    s5 = share16(p5);
    s7 = share16(p7);
    below_left_o = sat_err((ERR_BITS+1)'(pc_q) + (ERR_BITS+1)'(s3));
    pc_new       = sat_err((ERR_BITS+1)'(pn_q) + (ERR_BITS+1)'(s5));
  end

  assign bit_o   = on;
  assign below_o = pc_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q <= '0;
      pc_q <= '0;
      pn_q <= '0;
    end else if (adv_i) begin
      rc_q <= ctrl_i.last_col ? '0 : ERR_BITS'(s7);
      if (ctrl_i.last_col) begin
        pc_q <= '0;
        pn_q <= '0;
      end else begin
        pc_q <= pc_new;
        pn_q <= ERR_BITS'(s1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/error_diffusion_ditherer.sv
// Error diffusion ditherer top level: configuration, position, pipeline.
// Depends on edd_pkg, edd_line_buf and edd_chan.
//
// Takes one RGB pixel per clock in raster order and gives one 1-bit-per-channel
// word per pixel, passing the input register and then the result register. While
// every result is taken at once, a new pixel is taken every cycle; while a result
// waits, one more pixel is held in the input register and in_ready_o then stays
// low until the result is taken. The rate is set by the registered error feedback
// from one pixel to the next in the channel units. After reset the line buffer
// clears all MAX_WIDTH entries, during which in_ready_o is low; configuration
// writes are taken at any time and should be made only while the block is idle.
`default_nettype none

module error_diffusion_ditherer #(
  parameter int MAX_WIDTH = 2048,
  parameter int ERR_BITS  = 10
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [0:0]                  cfg_index_i,
  input  wire logic [edd_pkg::CFG_W-1:0]   cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [edd_pkg::PIX_W-1:0]   in_red_i,
  input  wire logic [edd_pkg::PIX_W-1:0]   in_green_i,
  input  wire logic [edd_pkg::PIX_W-1:0]   in_blue_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             out_red_o,
  output logic                             out_green_o,
  output logic                             out_blue_o,
  output logic                             frame_end_o
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int CFGW   = edd_pkg::CFG_W;
  localparam int RW     = edd_pkg::ROW_W;
  localparam int CMPW   = (CW > CFGW ? CW : CFGW) + 1;
  localparam int WORD_W = 3 * ERR_BITS;
  localparam int PW     = edd_pkg::PIX_W;

  logic [CFGW-1:0] width_q, height_q;
  logic [CMPW-1:0] width_ext, wm1_ext;
  logic [CW-1:0]   wm1, x;
  logic [RW-1:0]   hm1, y;
  logic [CW-1:0]   col_q;
  logic [RW-1:0]   row_q;
  logic            last_col, last_row;
  logic            in_acc, s1_adv, lb_busy;

  logic                 s1_valid_q;
  edd_pkg::pix_ctrl_t   s1_ctrl_q, s1_ctrl_d;
  logic [CW-1:0]        s1_x_q;
  logic [3*PW-1:0]      s1_pix_q;

  logic                 out_valid_q;
  logic [2:0]           out_bits_q;
  logic                 out_fe_q;

  logic [WORD_W-1:0] lb_rd_data, wr_a_word, wr_b_word;
  logic [2:0]        chan_bits;
  logic              wa_en, wb_en;
  logic              wr_en;
  logic [CW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              defer_q;
  logic [CW-1:0]     defer_addr_q;
  logic [WORD_W-1:0] defer_data_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFGW'(edd_pkg::WIDTH_RESET);
      height_q <= CFGW'(edd_pkg::HEIGHT_RESET);
    end else if (cfg_valid_i) begin
      unique case (edd_pkg::cfg_reg_e'(cfg_index_i))
        edd_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        edd_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    width_ext = CMPW'(width_q);
    if (width_q == '0) begin
      wm1_ext = '0;
    end else if (width_ext > CMPW'(MAX_WIDTH)) begin
      wm1_ext = CMPW'(MAX_WIDTH - 1);
    end else begin
      wm1_ext = width_ext - CMPW'(1);
    end
    wm1 = wm1_ext[CW-1:0];
    if (height_q == '0) begin
      hm1 = '0;
    end else if (height_q > CFGW'(edd_pkg::MAX_HEIGHT)) begin
      hm1 = RW'(edd_pkg::MAX_HEIGHT - 1);
    end else begin
      hm1 = RW'(height_q - CFGW'(1));
    end
    last_col = col_q >= wm1;
    last_row = row_q >= hm1;
    x        = last_col ? wm1 : col_q;
    y        = last_row ? hm1 : row_q;
    s1_ctrl_d.first_row = (y == '0);
    s1_ctrl_d.has_left  = (x != '0);
    s1_ctrl_d.last_col  = last_col;
    s1_ctrl_d.frame_end = last_col && last_row;
  end

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !lb_busy && (!s1_valid_q || s1_adv);
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : y + RW'(1);
      end else begin
        col_q <= x + CW'(1);
        row_q <= y;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_ctrl_q <= s1_ctrl_d;
      s1_x_q    <= x;
      s1_pix_q  <= {in_blue_i, in_green_i, in_red_i};
    end
  end

  edd_line_buf #(
    .DEPTH  (MAX_WIDTH),
    .WORD_W (WORD_W)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (x),
    .rd_data_o (lb_rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .busy_o    (lb_busy)
  );

  for (genvar c = 0; c < 3; c++) begin : g_chan
    edd_chan #(
      .ERR_BITS (ERR_BITS)
    ) u_chan (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .adv_i        (s1_adv),
      .ctrl_i       (s1_ctrl_q),
      .pix_i        (s1_pix_q[c*PW +: PW]),
      .line_err_i   ($signed(lb_rd_data[c*ERR_BITS +: ERR_BITS])),
      .bit_o        (chan_bits[c]),
      .below_left_o (wr_a_word[c*ERR_BITS +: ERR_BITS]),
      .below_o      (wr_b_word[c*ERR_BITS +: ERR_BITS])
    );
  end

  assign wa_en = s1_adv && s1_ctrl_q.has_left;
  assign wb_en = s1_adv && s1_ctrl_q.last_col;

  always_comb begin
    if (defer_q) begin
      wr_en   = 1'b1;
      wr_addr = defer_addr_q;
      wr_data = defer_data_q;
    end else if (wa_en) begin
      wr_en   = 1'b1;
      wr_addr = s1_x_q - CW'(1);
      wr_data = wr_a_word;
    end else if (wb_en) begin
      wr_en   = 1'b1;
      wr_addr = s1_x_q;
      wr_data = wr_b_word;
    end else begin
      wr_en   = 1'b0;
      wr_addr = s1_x_q;
      wr_data = wr_b_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      defer_q <= 1'b0;
    end else begin
      defer_q <= wa_en && wb_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wa_en && wb_en) begin
      defer_addr_q <= s1_x_q;
      defer_data_q <= wr_b_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_bits_q <= chan_bits;
      out_fe_q   <= s1_ctrl_q.frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_bits_q[0];
  assign out_green_o = out_bits_q[1];
  assign out_blue_o  = out_bits_q[2];
  assign frame_end_o = out_fe_q;

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lb_busy |-> !in_acc)
    else $error("pixel accepted during line buffer clear");

  a_defer_port_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    defer_q |-> !(wa_en || wb_en))
    else $error("deferred write collides with a pixel write");

  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("advanced pixel did not reach the result register");

  a_defer_after_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    defer_q |-> $past(s1_ctrl_q.last_col))
    else $error("deferred write without a row end");

endmodule

`default_nettype wire
